[hdl/ubx_nrd_pkg.sv]
// ----------------------------------------------------------------------------
// UBX navigation reply decoder: shared types and constants
// Frame constants, reply kinds, status codes, capture slot map and the
// result record that travels down the output pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package ubx_nrd_pkg;

	// Widths of the stream ports.
	localparam int unsigned IN_DATA_W  = 8;
	localparam int unsigned IN_USER_W  = 3;
	localparam int unsigned OUT_DATA_W = 136;
	localparam int unsigned OUT_USER_W = 2;

	// Frame position counter and capture store.
	localparam int unsigned POS_W     = 6;
	localparam int unsigned CAP_SLOTS = 14;

	typedef logic [POS_W-1:0] pos_t;
	typedef logic [3:0]       slot_t;
	typedef logic [7:0]       byte_t;

	// Sync pair and class/id codes.
	localparam byte_t SYNC_CHAR_1 = 8'hB5;
	localparam byte_t SYNC_CHAR_2 = 8'h62;
	localparam byte_t CLASS_NAV   = 8'h01;
	localparam byte_t CLASS_CFG   = 8'h06;
	localparam byte_t ID_NAV_SOL  = 8'h06;
	localparam byte_t ID_POSLLH   = 8'h02;
	localparam byte_t ID_TIMEUTC  = 8'h21;
	localparam byte_t ID_NAV5     = 8'h24;

	// Lengths of the four replies from the class byte to the last summed byte.
	localparam pos_t LEN_NAV_SOL = 6'd56;
	localparam pos_t LEN_POSLLH  = 6'd32;
	localparam pos_t LEN_TIMEUTC = 6'd24;
	localparam pos_t LEN_NAV5    = 6'd40;

	// Limits used when the kept values are updated.
	localparam byte_t SATS_MIN   = 8'd4;
	localparam byte_t HOUR_MAX   = 8'd23;
	localparam byte_t MIN_SEC_MAX = 8'd59;

	// Division of altitude by 1000: q = (u * ALT_RECIP) >> ALT_SHIFT, exact
	// for every unsigned u below 2^32.
	localparam logic [31:0] ALT_RECIP = 32'd2199023256;
	localparam int unsigned ALT_SHIFT = 41;
	localparam int unsigned ALT_W     = 23;

	typedef enum logic [1:0] {
		KIND_NAV_SOL    = 2'd0,
		KIND_NAV_POSLLH = 2'd1,
		KIND_NAV_TIMEUTC = 2'd2,
		KIND_CFG_NAV5   = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_BAD_SYNC = 3'd1,
		ST_BAD_ID   = 3'd2,
		ST_BAD_SUM  = 3'd3,
		ST_BAD_TIME = 3'd4
	} status_t;

	// Where a capture slot sits in the frame for a given reply kind.
	typedef struct packed {
		logic hit;
		pos_t pos;
	} slot_map_t;

	// One decoded result, apart from the altitude which is divided later.
	typedef struct packed {
		kind_t        kind;
		status_t      status;
		byte_t        fix_type;
		byte_t        sat_count;
		byte_t        dyn_model;
		logic [31:0]  longitude;
		logic [31:0]  latitude;
		logic [4:0]   hour;
		logic [5:0]   minute;
		logic [5:0]   second;
	} result_t;

	function automatic byte_t exp_class(input kind_t k);
		byte_t r;
		unique case (k)
			KIND_CFG_NAV5: r = CLASS_CFG;
			default:       r = CLASS_NAV;
		endcase
		return r;
	endfunction

	function automatic byte_t exp_id(input kind_t k);
		byte_t r;
		unique case (k)
			KIND_NAV_SOL:     r = ID_NAV_SOL;
			KIND_NAV_POSLLH:  r = ID_POSLLH;
			KIND_NAV_TIMEUTC: r = ID_TIMEUTC;
			default:          r = ID_NAV5;
		endcase
		return r;
	endfunction

	function automatic pos_t body_len(input kind_t k);
		pos_t r;
		unique case (k)
			KIND_NAV_SOL:     r = LEN_NAV_SOL;
			KIND_NAV_POSLLH:  r = LEN_POSLLH;
			KIND_NAV_TIMEUTC: r = LEN_TIMEUTC;
			default:          r = LEN_NAV5;
		endcase
		return r;
	endfunction

	// Frame position of each capture slot for each reply kind.
	function automatic slot_map_t slot_pos(input kind_t k, input slot_t s);
		slot_map_t r;
		r.hit = 1'b0;
		r.pos = '0;
		unique case (k)
			KIND_NAV_SOL: begin
				if (s == 4'd0) begin
					r.hit = 1'b1;
					r.pos = 6'd16;
				end else if (s == 4'd1) begin
					r.hit = 1'b1;
					r.pos = 6'd17;
				end else if (s == 4'd2) begin
					r.hit = 1'b1;
					r.pos = 6'd53;
				end
			end
			KIND_NAV_POSLLH: begin
				if (s < 4'd8) begin
					r.hit = 1'b1;
					r.pos = 6'd10 + {2'b00, s};
				end else if (s < 4'd12) begin
					r.hit = 1'b1;
					r.pos = 6'd14 + {2'b00, s};
				end
			end
			KIND_NAV_TIMEUTC: begin
				if (s < 4'd3) begin
					r.hit = 1'b1;
					r.pos = 6'd22 + {2'b00, s};
				end
			end
			default: begin
				if (s == 4'd0) begin
					r.hit = 1'b1;
					r.pos = 6'd8;
				end
			end
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

[hdl/ubx_nav_response_decoder.sv]
// A result passes through stage 1, stage 2 and the output register, all stallable.
// Throughput: one byte per cycle unless s_tready is low; each byte updates the
// running Fletcher sums, checks and capture slots in the cycle it is taken.
// The altitude divide by 1000 runs through a registered 32 x 32 multiply stage.
// Reset clears the frame state, all kept values and every pipeline valid flag.
// ----------------------------------------------------------------------------
// UBX navigation reply decoder
// Checks sync, class/id and the Fletcher-8 checksum of one reply, captures
// fields at fixed offsets and emits a status with the kept values per frame.
// ----------------------------------------------------------------------------
`default_nettype none

module ubx_nav_response_decoder #(
	parameter int FRAME_BYTES = 60
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	// rx_byte[7:0]
	input  wire logic [ubx_nrd_pkg::IN_DATA_W-1:0]   s_tdata,
	// req_type[1:0], frame_cut[2]
	input  wire logic [ubx_nrd_pkg::IN_USER_W-1:0]   s_tuser,
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// status[2:0], fix_type[10:3], sat_count[18:11], dyn_model[26:19],
	// longitude[58:27], latitude[90:59], altitude_m[113:91], hour_utc[118:114],
	// minute_utc[124:119], second_utc[130:125], zero fill[135:131]
	output logic [ubx_nrd_pkg::OUT_DATA_W-1:0]       m_tdata,
	// reply_kind[1:0]
	output logic [ubx_nrd_pkg::OUT_USER_W-1:0]       m_tuser
);

	localparam int unsigned POS_W_P1 = ubx_nrd_pkg::POS_W;

	// Frame state.
	ubx_nrd_pkg::pos_t  byte_pos_q;
	ubx_nrd_pkg::byte_t sum_a_q;
	ubx_nrd_pkg::byte_t sum_b_q;
	logic               sync_bad_q;
	logic               id_bad_q;
	logic               sum_bad_q;
	ubx_nrd_pkg::byte_t cap_q [ubx_nrd_pkg::CAP_SLOTS];

	// Kept values.
	ubx_nrd_pkg::byte_t fix_q;
	ubx_nrd_pkg::byte_t sats_q;
	ubx_nrd_pkg::byte_t model_q;
	logic [31:0]        lon_q;
	logic [31:0]        lat_q;
	logic [31:0]        alt_mm_q;
	logic [4:0]         hour_q;
	logic [5:0]         minute_q;
	logic [5:0]         second_q;

	// Input decode.
	ubx_nrd_pkg::kind_t in_kind;
	logic               in_cut;
	ubx_nrd_pkg::byte_t in_byte;
	logic               accept;

	// Per-byte update.
	ubx_nrd_pkg::pos_t  len;
	logic               in_sum;
	ubx_nrd_pkg::byte_t sum_a_add;
	ubx_nrd_pkg::byte_t n_sum_a;
	ubx_nrd_pkg::byte_t n_sum_b;
	logic               n_sync;
	logic               n_id;
	logic               n_sumbad;
	logic [POS_W_P1:0]  pos_inc;
	logic               n_end;
	ubx_nrd_pkg::byte_t n_cap [ubx_nrd_pkg::CAP_SLOTS];

	// Timeout: the rest of the frame filled with zero bytes.
	ubx_nrd_pkg::pos_t  sum_start;
	ubx_nrd_pkg::pos_t  zero_cnt;
	logic [13:0]        zero_prod;
	ubx_nrd_pkg::byte_t c_sum_b;
	logic               c_sync;
	logic               c_id;
	logic               c_sumbad;
	ubx_nrd_pkg::byte_t c_cap [ubx_nrd_pkg::CAP_SLOTS];

	// Frame end view.
	logic               f_sync;
	logic               f_id;
	logic               f_sumbad;
	logic               f_end;
	ubx_nrd_pkg::byte_t f_cap [ubx_nrd_pkg::CAP_SLOTS];

	// Kept values after this frame.
	ubx_nrd_pkg::status_t st;
	ubx_nrd_pkg::byte_t   k_fix;
	ubx_nrd_pkg::byte_t   k_sats;
	ubx_nrd_pkg::byte_t   k_model;
	logic [31:0]          k_lon;
	logic [31:0]          k_lat;
	logic [31:0]          k_alt;
	logic [4:0]           k_hour;
	logic [5:0]           k_minute;
	logic [5:0]           k_second;
	logic [31:0]          k_alt_mag;
	ubx_nrd_pkg::result_t k_res;

	// Output pipeline.
	logic                 rdy_out;
	logic                 rdy_s2;
	logic                 rdy_s1;
	logic                 valid_s1;
	logic                 valid_s2;
	logic                 out_valid_q;
	ubx_nrd_pkg::result_t res_s1;
	ubx_nrd_pkg::result_t res_s2;
	ubx_nrd_pkg::result_t res_q;
	logic [31:0]          alt_mag_s1;
	logic                 alt_neg_s1;
	logic                 alt_neg_s2;
	logic [63:0]          alt_prod_s2;
	logic [ubx_nrd_pkg::ALT_W-1:0] alt_q;
	logic [ubx_nrd_pkg::ALT_W-1:0] alt_quot;

	// Input fields and handshake.
	assign in_kind = ubx_nrd_pkg::kind_t'(s_tuser[1:0]);
	assign in_cut  = s_tuser[2];
	assign in_byte = s_tdata[7:0];
	assign accept  = s_tvalid && s_tready;

	// Checks, running sums and captures for one received byte.
	always_comb begin
		len       = ubx_nrd_pkg::body_len(in_kind);
		in_sum    = (byte_pos_q >= 6'd2) && (byte_pos_q <= len + 6'd1);
		sum_a_add = sum_a_q + in_byte;
		n_sum_a   = in_sum ? sum_a_add : sum_a_q;
		n_sum_b   = in_sum ? (sum_b_q + sum_a_add) : sum_b_q;
		n_sync    = sync_bad_q
			|| ((byte_pos_q == 6'd0) && (in_byte != ubx_nrd_pkg::SYNC_CHAR_1))
			|| ((byte_pos_q == 6'd1) && (in_byte != ubx_nrd_pkg::SYNC_CHAR_2));
		n_id      = id_bad_q
			|| ((byte_pos_q == 6'd2) && (in_byte != ubx_nrd_pkg::exp_class(in_kind)))
			|| ((byte_pos_q == 6'd3) && (in_byte != ubx_nrd_pkg::exp_id(in_kind)));
		n_sumbad  = sum_bad_q
			|| ((byte_pos_q == len + 6'd2) && (in_byte != sum_a_q))
			|| ((byte_pos_q == len + 6'd3) && (in_byte != sum_b_q));
		pos_inc   = {1'b0, byte_pos_q} + 7'd1;
		n_end     = pos_inc >= 7'(FRAME_BYTES);
		for (int s = 0; s < ubx_nrd_pkg::CAP_SLOTS; s++) begin
			ubx_nrd_pkg::slot_map_t sm;
			sm = ubx_nrd_pkg::slot_pos(in_kind, 4'(s));
			n_cap[s] = (sm.hit && (sm.pos == byte_pos_q)) ? in_byte : cap_q[s];
		end
	end

	// Timeout: zero bytes leave sum A alone and add sum A once per remaining
	// summed position to sum B; they fail any sync or id check still ahead, and a checksum check unless it meets zero.
	always_comb begin
		sum_start = (byte_pos_q < 6'd2) ? 6'd2 : byte_pos_q;
		zero_cnt  = (byte_pos_q <= len + 6'd1) ? (len + 6'd2 - sum_start) : 6'd0;
		zero_prod = sum_a_q * zero_cnt;
		c_sum_b   = sum_b_q + zero_prod[7:0];
		c_sync    = sync_bad_q || (byte_pos_q <= 6'd1);
		c_id      = id_bad_q || (byte_pos_q <= 6'd3);
		c_sumbad  = sum_bad_q
			|| ((byte_pos_q <= len + 6'd2) && (sum_a_q != 8'd0))
			|| ((byte_pos_q <= len + 6'd3) && (c_sum_b != 8'd0));
		for (int s = 0; s < ubx_nrd_pkg::CAP_SLOTS; s++) begin
			ubx_nrd_pkg::slot_map_t sm;
			sm = ubx_nrd_pkg::slot_pos(in_kind, 4'(s));
			c_cap[s] = (sm.hit && (sm.pos >= byte_pos_q)) ? 8'd0 : cap_q[s];
		end
	end

	// State of the frame as it ends on this transfer.
	always_comb begin
		f_sync   = in_cut ? c_sync : n_sync;
		f_id     = in_cut ? c_id : n_id;
		f_sumbad = in_cut ? c_sumbad : n_sumbad;
		f_end    = in_cut || n_end;
		for (int s = 0; s < ubx_nrd_pkg::CAP_SLOTS; s++) begin
			f_cap[s] = in_cut ? c_cap[s] : n_cap[s];
		end
	end

	// Status and kept values after the frame is decoded.
	always_comb begin
		priority if (f_sumbad) begin
			st = ubx_nrd_pkg::ST_BAD_SUM;
		end else if (f_id) begin
			st = ubx_nrd_pkg::ST_BAD_ID;
		end else if (f_sync) begin
			st = ubx_nrd_pkg::ST_BAD_SYNC;
		end else begin
			st = ubx_nrd_pkg::ST_OK;
		end
		k_fix    = fix_q;
		k_sats   = sats_q;
		k_model  = model_q;
		k_lon    = lon_q;
		k_lat    = lat_q;
		k_alt    = alt_mm_q;
		k_hour   = hour_q;
		k_minute = minute_q;
		k_second = second_q;
		unique case (in_kind)
			ubx_nrd_pkg::KIND_NAV_SOL: begin
				if (st == ubx_nrd_pkg::ST_OK) begin
					k_fix  = f_cap[1][0] ? f_cap[0] : 8'd0;
					k_sats = f_cap[2];
				end else begin
					k_fix = 8'd0;
				end
			end
			ubx_nrd_pkg::KIND_NAV_POSLLH: begin
				if (st == ubx_nrd_pkg::ST_OK) begin
					if (sats_q < ubx_nrd_pkg::SATS_MIN) begin
						k_lon = '0;
						k_lat = '0;
						k_alt = '0;
					end else begin
						k_lon = {f_cap[3], f_cap[2], f_cap[1], f_cap[0]};
						k_lat = {f_cap[7], f_cap[6], f_cap[5], f_cap[4]};
						k_alt = {f_cap[11], f_cap[10], f_cap[9], f_cap[8]};
					end
				end
			end
			ubx_nrd_pkg::KIND_NAV_TIMEUTC: begin
				if (st == ubx_nrd_pkg::ST_OK) begin
					if ((f_cap[0] > ubx_nrd_pkg::HOUR_MAX)
						|| (f_cap[1] > ubx_nrd_pkg::MIN_SEC_MAX)
						|| (f_cap[2] > ubx_nrd_pkg::MIN_SEC_MAX)) begin
						st = ubx_nrd_pkg::ST_BAD_TIME;
					end else begin
						k_hour   = f_cap[0][4:0];
						k_minute = f_cap[1][5:0];
						k_second = f_cap[2][5:0];
					end
				end
			end
			default: begin
				k_model = f_cap[0];
			end
		endcase
		k_alt_mag = k_alt[31] ? (32'd0 - k_alt) : k_alt;

		k_res.kind      = in_kind;
		k_res.status    = st;
		k_res.fix_type  = k_fix;
		k_res.sat_count = k_sats;
		k_res.dyn_model = k_model;
		k_res.longitude = k_lon;
		k_res.latitude  = k_lat;
		k_res.hour      = k_hour;
		k_res.minute    = k_minute;
		k_res.second    = k_second;
	end

	// Frame state and kept values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_pos_q <= '0;
			sum_a_q    <= '0;
			sum_b_q    <= '0;
			sync_bad_q <= 1'b0;
			id_bad_q   <= 1'b0;
			sum_bad_q  <= 1'b0;
			for (int s = 0; s < ubx_nrd_pkg::CAP_SLOTS; s++) begin
				cap_q[s] <= '0;
			end
			fix_q    <= '0;
			sats_q   <= '0;
			model_q  <= '0;
			lon_q    <= '0;
			lat_q    <= '0;
			alt_mm_q <= '0;
			hour_q   <= '0;
			minute_q <= '0;
			second_q <= '0;
		end else if (accept) begin
			if (f_end) begin
				byte_pos_q <= '0;
				sum_a_q    <= '0;
				sum_b_q    <= '0;
				sync_bad_q <= 1'b0;
				id_bad_q   <= 1'b0;
				sum_bad_q  <= 1'b0;
				for (int s = 0; s < ubx_nrd_pkg::CAP_SLOTS; s++) begin
					cap_q[s] <= '0;
				end
				fix_q    <= k_fix;
				sats_q   <= k_sats;
				model_q  <= k_model;
				lon_q    <= k_lon;
				lat_q    <= k_lat;
				alt_mm_q <= k_alt;
				hour_q   <= k_hour;
				minute_q <= k_minute;
				second_q <= k_second;
			end else begin
				byte_pos_q <= pos_inc[POS_W_P1-1:0];
				sum_a_q    <= n_sum_a;
				sum_b_q    <= n_sum_b;
				sync_bad_q <= n_sync;
				id_bad_q   <= n_id;
				sum_bad_q  <= n_sumbad;
				for (int s = 0; s < ubx_nrd_pkg::CAP_SLOTS; s++) begin
					cap_q[s] <= n_cap[s];
				end
			end
		end
	end

	// Each stage moves on when it is empty or the next stage takes its contents.
	assign rdy_out  = !out_valid_q || m_tready;
	assign rdy_s2   = !valid_s2 || rdy_out;
	assign rdy_s1   = !valid_s1 || rdy_s2;
	assign s_tready = rdy_s1;

	// Pipeline valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy_s1) begin
				valid_s1 <= accept && f_end;
			end
			if (rdy_s2) begin
				valid_s2 <= valid_s1;
			end
			if (rdy_out) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	// Altitude magnitude times the reciprocal of 1000, then shift and sign.
	assign alt_quot = alt_prod_s2[ubx_nrd_pkg::ALT_SHIFT +: ubx_nrd_pkg::ALT_W];

	always_ff @(posedge clk) begin
		if (rdy_s1 && accept && f_end) begin
			res_s1     <= k_res;
			alt_mag_s1 <= k_alt_mag;
			alt_neg_s1 <= k_alt[31];
		end
		if (rdy_s2 && valid_s1) begin
			res_s2      <= res_s1;
			alt_neg_s2  <= alt_neg_s1;
			alt_prod_s2 <= alt_mag_s1 * ubx_nrd_pkg::ALT_RECIP;
		end
		if (rdy_out && valid_s2) begin
			res_q <= res_s2;
			alt_q <= alt_neg_s2 ? (23'd0 - alt_quot) : alt_quot;
		end
	end

	// Result transfer.
	assign m_tvalid = out_valid_q;
	assign m_tuser  = res_q.kind;
	assign m_tdata  = {5'd0, res_q.second, res_q.minute, res_q.hour, alt_q,
		res_q.latitude, res_q.longitude, res_q.dyn_model, res_q.sat_count,
		res_q.fix_type, res_q.status};

endmodule

`default_nettype wire

[test/ubx_nav_response_decoder_test.sv]
// ----------------------------------------------------------------------------
// Testbench for the UBX navigation reply decoder
// Drives whole and broken replies of all four kinds byte by byte, predicts
// each frame result in a behavioural decoder and checks every output transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module ubx_nav_response_decoder_test;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAME_LEN    = 60;
	localparam int CYCLE_LIMIT  = 300000;
	localparam int DRAIN_CYCLES = 12;
	localparam int ITEMS_TARGET = 1650;
	localparam int HOLD_CYCLES  = 300;
	localparam int SHOWN_ERRORS = 10;
	localparam int MIN_FRAMES   = 16;

	// Class, id and summed length (class byte onward) of each reply kind, indexed by kind.
	localparam ubx_nrd_pkg::byte_t MSG_CLASS [4] = '{ubx_nrd_pkg::CLASS_NAV,
		ubx_nrd_pkg::CLASS_NAV, ubx_nrd_pkg::CLASS_NAV, ubx_nrd_pkg::CLASS_CFG};
	localparam ubx_nrd_pkg::byte_t MSG_ID [4] = '{ubx_nrd_pkg::ID_NAV_SOL,
		ubx_nrd_pkg::ID_POSLLH, ubx_nrd_pkg::ID_TIMEUTC, ubx_nrd_pkg::ID_NAV5};
	localparam int PAYLOAD_LEN [4] = '{int'(ubx_nrd_pkg::LEN_NAV_SOL),
		int'(ubx_nrd_pkg::LEN_POSLLH), int'(ubx_nrd_pkg::LEN_TIMEUTC),
		int'(ubx_nrd_pkg::LEN_NAV5)};

	typedef ubx_nrd_pkg::byte_t frame_q_t[$];

	// One decoded frame as it should leave the block.
	typedef struct {
		ubx_nrd_pkg::kind_t   kind;
		ubx_nrd_pkg::status_t status;
		ubx_nrd_pkg::byte_t   fix_type;
		ubx_nrd_pkg::byte_t   sat_count;
		ubx_nrd_pkg::byte_t   dyn_model;
		logic [31:0] longitude;
		logic [31:0] latitude;
		logic [22:0] altitude;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
	} nav_report_t;

	logic clk;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [ubx_nrd_pkg::IN_DATA_W-1:0] s_tdata = '0;
	logic [ubx_nrd_pkg::IN_USER_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [ubx_nrd_pkg::OUT_DATA_W-1:0] m_tdata;
	logic [ubx_nrd_pkg::OUT_USER_W-1:0] m_tuser;

	// Run control shared by the sender, the receiver and the tests.
	bit gaps_on = 1'b1;
	int hold_len = 0;
	int cycle_count = 0;
	int mismatches = 0;
	int items_sent = 0;
	int cuts_sent = 0;
	int reports_checked = 0;
	int clean_frames = 0;
	int frames_closed = 0;

	nav_report_t pending_reports[$];

	// Behavioural decoder state: the frame in progress and the kept values.
	int nav_pos;
	ubx_nrd_pkg::byte_t run_a, run_b;
	bit sync_err, id_err, sum_err;
	ubx_nrd_pkg::byte_t cap [ubx_nrd_pkg::CAP_SLOTS];
	ubx_nrd_pkg::byte_t fix_hold, sats_hold, model_hold;
	logic [31:0] lon_hold, lat_hold, alt_hold;
	logic [4:0] hour_hold;
	logic [5:0] min_hold, sec_hold;

	ubx_nav_response_decoder #(
		.FRAME_BYTES(FRAME_LEN)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Behavioural decoder
	// ------------------------------------------------------------------

	// Capture slot that a frame position feeds for a given kind, or -1.
	function automatic int cap_slot(ubx_nrd_pkg::kind_t k, int p);
		int s;
		s = -1;
		case (k)
			ubx_nrd_pkg::KIND_NAV_SOL: begin
				if (p == 16) s = 0;
				else if (p == 17) s = 1;
				else if (p == 53) s = 2;
			end
			ubx_nrd_pkg::KIND_NAV_POSLLH: begin
				if (p >= 10 && p <= 17) s = p - 10;
				else if (p >= 22 && p <= 25) s = p - 14;
			end
			ubx_nrd_pkg::KIND_NAV_TIMEUTC: begin
				if (p >= 22 && p <= 24) s = p - 22;
			end
			default: begin
				if (p == 8) s = 0;
			end
		endcase
		return s;
	endfunction

	function automatic void clear_frame_state();
		nav_pos = 0;
		run_a = '0;
		run_b = '0;
		sync_err = 1'b0;
		id_err = 1'b0;
		sum_err = 1'b0;
		foreach (cap[i]) cap[i] = '0;
	endfunction

	// One byte through the sync, id, checksum and capture checks.
	function automatic void decode_byte(ubx_nrd_pkg::kind_t k, ubx_nrd_pkg::byte_t b);
		int len;
		int s;
		len = PAYLOAD_LEN[k];
		if (nav_pos == 0 && b != ubx_nrd_pkg::SYNC_CHAR_1) sync_err = 1'b1;
		if (nav_pos == 1 && b != ubx_nrd_pkg::SYNC_CHAR_2) sync_err = 1'b1;
		if (nav_pos == 2 && b != MSG_CLASS[k]) id_err = 1'b1;
		if (nav_pos == 3 && b != MSG_ID[k]) id_err = 1'b1;
		if (nav_pos >= 2 && nav_pos <= len + 1) begin
			run_a = run_a + b;
			run_b = run_b + run_a;
		end
		if (nav_pos == len + 2 && b != run_a) sum_err = 1'b1;
		if (nav_pos == len + 3 && b != run_b) sum_err = 1'b1;
		s = cap_slot(k, nav_pos);
		if (s >= 0) cap[s] = b;
		if (nav_pos < 63) nav_pos++;
	endfunction

	// Frame end: update the kept values and form the result.
	function automatic nav_report_t close_frame(ubx_nrd_pkg::kind_t k);
		nav_report_t r;
		ubx_nrd_pkg::status_t st;
		int mm;
		if (sum_err) st = ubx_nrd_pkg::ST_BAD_SUM;
		else if (id_err) st = ubx_nrd_pkg::ST_BAD_ID;
		else if (sync_err) st = ubx_nrd_pkg::ST_BAD_SYNC;
		else st = ubx_nrd_pkg::ST_OK;
		case (k)
			ubx_nrd_pkg::KIND_NAV_SOL: begin
				if (st == ubx_nrd_pkg::ST_OK) begin
					fix_hold = cap[1][0] ? cap[0] : 8'h00;
					sats_hold = cap[2];
				end else begin
					fix_hold = 8'h00;
				end
			end
			ubx_nrd_pkg::KIND_NAV_POSLLH: begin
				if (st == ubx_nrd_pkg::ST_OK) begin
					if (sats_hold < ubx_nrd_pkg::SATS_MIN) begin
						lon_hold = '0;
						lat_hold = '0;
						alt_hold = '0;
					end else begin
						lon_hold = {cap[3], cap[2], cap[1], cap[0]};
						lat_hold = {cap[7], cap[6], cap[5], cap[4]};
						mm = $signed({cap[11], cap[10], cap[9], cap[8]});
						// Integer division truncates toward zero.
						alt_hold = mm / 1000;
					end
				end
			end
			ubx_nrd_pkg::KIND_NAV_TIMEUTC: begin
				if (st == ubx_nrd_pkg::ST_OK) begin
					if (cap[0] > ubx_nrd_pkg::HOUR_MAX
						|| cap[1] > ubx_nrd_pkg::MIN_SEC_MAX
						|| cap[2] > ubx_nrd_pkg::MIN_SEC_MAX) begin
						st = ubx_nrd_pkg::ST_BAD_TIME;
					end else begin
						hour_hold = cap[0][4:0];
						min_hold = cap[1][5:0];
						sec_hold = cap[2][5:0];
					end
				end
			end
			default: begin
				// The model byte is taken whatever the status.
				model_hold = cap[0];
			end
		endcase
		r.kind = k;
		r.status = st;
		r.fix_type = fix_hold;
		r.sat_count = sats_hold;
		r.dyn_model = model_hold;
		r.longitude = lon_hold;
		r.latitude = lat_hold;
		r.altitude = alt_hold[22:0];
		r.hour = hour_hold;
		r.minute = min_hold;
		r.second = sec_hold;
		if (st == ubx_nrd_pkg::ST_OK) clean_frames++;
		frames_closed++;
		clear_frame_state();
		return r;
	endfunction

	// Work out what an accepted transfer produces.
	function automatic void predict_item(ubx_nrd_pkg::kind_t k, ubx_nrd_pkg::byte_t b,
			bit cut);
		if (cut) begin
			// A timeout fills the rest of the frame with zero bytes.
			while (nav_pos < FRAME_LEN) decode_byte(k, 8'h00);
			pending_reports.push_back(close_frame(k));
		end else begin
			decode_byte(k, b);
			if (nav_pos >= FRAME_LEN) pending_reports.push_back(close_frame(k));
		end
	endfunction

	initial begin
		clear_frame_state();
		fix_hold = '0;
		sats_hold = '0;
		model_hold = '0;
		lon_hold = '0;
		lat_hold = '0;
		alt_hold = '0;
		hour_hold = '0;
		min_hold = '0;
		sec_hold = '0;
	end

	// ------------------------------------------------------------------
	// Checking of output transfers
	// ------------------------------------------------------------------

	function automatic void check_field(string what, logic [31:0] want, logic [31:0] seen);
		if (want !== seen) begin
			mismatches++;
			if (mismatches <= SHOWN_ERRORS)
				$display("Mismatch in %s of result %0d: expected 0x%0h, got 0x%0h",
					what, reports_checked, want, seen);
		end
	endfunction

	function automatic void take_report();
		nav_report_t want;
		if (pending_reports.size() == 0) begin
			mismatches++;
			if (mismatches <= SHOWN_ERRORS)
				$display("Unexpected result transfer: kind %0d, status %0d",
					m_tuser, m_tdata[2:0]);
		end else begin
			want = pending_reports.pop_front();
			check_field("reply_kind", want.kind, m_tuser);
			check_field("status", want.status, m_tdata[2:0]);
			check_field("fix_type", want.fix_type, m_tdata[10:3]);
			check_field("sat_count", want.sat_count, m_tdata[18:11]);
			check_field("dyn_model", want.dyn_model, m_tdata[26:19]);
			check_field("longitude", want.longitude, m_tdata[58:27]);
			check_field("latitude", want.latitude, m_tdata[90:59]);
			check_field("altitude_m", want.altitude, m_tdata[113:91]);
			check_field("hour_utc", want.hour, m_tdata[118:114]);
			check_field("minute_utc", want.minute, m_tdata[124:119]);
			check_field("second_utc", want.second, m_tdata[130:125]);
			reports_checked++;
		end
	endfunction

	// Values read here are those from just before the edge.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) take_report();
	end

	// Receiver: random back-pressure, plus a long hold-off on request.
	initial begin : receiver
		forever begin
			@(posedge clk);
			if (hold_len != 0) begin
				m_tready <= 1'b0;
				repeat (hold_len) @(posedge clk);
				hold_len = 0;
			end
			m_tready <= !(gaps_on && $urandom_range(0, 99) < 20);
		end
	end

	// Watchdog on the whole run.
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: failure");
		$finish;
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Offer one byte or timeout and wait for its transfer.
	task automatic send_item(input ubx_nrd_pkg::kind_t k, input ubx_nrd_pkg::byte_t b,
			input bit cut);
		if (gaps_on && $urandom_range(0, 99) < 20) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 2)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= {cut, k};
		do @(posedge clk); while (!s_tready);
		items_sent++;
		if (cut) cuts_sent++;
		predict_item(k, b, cut);
	endtask

	task automatic drain_reports();
		s_tvalid <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// A reply with random payload and plausible values in the kept fields.
	function automatic frame_q_t build_frame(ubx_nrd_pkg::kind_t k);
		frame_q_t fr;
		int len;
		len = PAYLOAD_LEN[k];
		fr.push_back(ubx_nrd_pkg::SYNC_CHAR_1);
		fr.push_back(ubx_nrd_pkg::SYNC_CHAR_2);
		fr.push_back(MSG_CLASS[k]);
		fr.push_back(MSG_ID[k]);
		for (int i = 4; i < len + 4; i++)
			fr.push_back(ubx_nrd_pkg::byte_t'($urandom_range(0, 255)));
		case (k)
			ubx_nrd_pkg::KIND_NAV_SOL: begin
				fr[16] = ubx_nrd_pkg::byte_t'($urandom_range(0, 5));
				fr[17][0] = ($urandom_range(0, 3) != 0);
				fr[53] = ($urandom_range(0, 3) == 0)
					? ubx_nrd_pkg::byte_t'($urandom_range(0, 255))
					: ubx_nrd_pkg::byte_t'($urandom_range(0, 12));
			end
			ubx_nrd_pkg::KIND_NAV_TIMEUTC: begin
				fr[22] = ($urandom_range(0, 9) == 0)
					? ubx_nrd_pkg::byte_t'($urandom_range(0, 255))
					: ubx_nrd_pkg::byte_t'($urandom_range(0, 23));
				fr[23] = ($urandom_range(0, 9) == 0)
					? ubx_nrd_pkg::byte_t'($urandom_range(0, 255))
					: ubx_nrd_pkg::byte_t'($urandom_range(0, 59));
				fr[24] = ($urandom_range(0, 9) == 0)
					? ubx_nrd_pkg::byte_t'($urandom_range(0, 255))
					: ubx_nrd_pkg::byte_t'($urandom_range(0, 59));
			end
			default: ;
		endcase
		return fr;
	endfunction

	function automatic void set_word(ref frame_q_t fr, input int at, input logic [31:0] w);
		for (int i = 0; i < 4; i++) fr[at + i] = w[8*i +: 8];
	endfunction

	// Write the Fletcher-8 pair after the payload.
	function automatic void seal_frame(ref frame_q_t fr, input ubx_nrd_pkg::kind_t k);
		ubx_nrd_pkg::byte_t a, b;
		int len;
		len = PAYLOAD_LEN[k];
		a = '0;
		b = '0;
		for (int i = 2; i <= len + 1; i++) begin
			a = a + fr[i];
			b = b + a;
		end
		fr[len + 2] = a;
		fr[len + 3] = b;
	endfunction

	// Send a frame; bytes from switch_at on go under k_late. The frame is
	// closed by a timeout or by trailing bytes up to its full length.
	task automatic send_frame(input ubx_nrd_pkg::kind_t k, input frame_q_t fr,
			input ubx_nrd_pkg::kind_t k_late, input int switch_at, input bit end_by_cut);
		int idx;
		idx = 0;
		foreach (fr[i]) begin
			send_item((idx >= switch_at) ? k_late : k, fr[i], 1'b0);
			idx++;
		end
		if (nav_pos != 0) begin
			if (end_by_cut) begin
				send_item((idx >= switch_at) ? k_late : k,
					ubx_nrd_pkg::byte_t'($urandom_range(0, 255)), 1'b1);
			end else begin
				while (nav_pos != 0) begin
					send_item((idx >= switch_at) ? k_late : k,
						ubx_nrd_pkg::byte_t'($urandom_range(0, 255)), 1'b0);
					idx++;
				end
			end
		end
	endtask

	task automatic send_sealed(input ubx_nrd_pkg::kind_t k, input frame_q_t fr,
			input bit end_by_cut);
		seal_frame(fr, k);
		send_frame(k, fr, k, FRAME_LEN, end_by_cut);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Timeouts with no bytes decode a frame of all zero bytes.
	task automatic test_empty_timeouts();
		for (int k = 0; k < 4; k++) send_item(ubx_nrd_pkg::kind_t'(k), 8'hFF, 1'b1);
		drain_reports();
	endtask

	// Good replies with field extremes, low satellite count and bad times.
	task automatic test_wellformed_frames();
		frame_q_t fr;

		fr = build_frame(ubx_nrd_pkg::KIND_NAV_SOL);
		fr[16] = 8'hFF;
		fr[17] = 8'hFF;
		fr[53] = 8'hFF;
		send_sealed(ubx_nrd_pkg::KIND_NAV_SOL, fr, 1'b0);

		fr = build_frame(ubx_nrd_pkg::KIND_NAV_POSLLH);
		set_word(fr, 10, 32'h8000_0000);
		set_word(fr, 14, 32'h7FFF_FFFF);
		set_word(fr, 22, 32'h8000_0000);
		send_sealed(ubx_nrd_pkg::KIND_NAV_POSLLH, fr, 1'b1);

		fr = build_frame(ubx_nrd_pkg::KIND_NAV_POSLLH);
		set_word(fr, 10, 32'h7FFF_FFFF);
		set_word(fr, 14, 32'h8000_0000);
		set_word(fr, 22, 32'h7FFF_FFFF);
		send_sealed(ubx_nrd_pkg::KIND_NAV_POSLLH, fr, 1'b0);

		// Small negative heights round toward zero.
		fr = build_frame(ubx_nrd_pkg::KIND_NAV_POSLLH);
		set_word(fr, 22, -32'sd999);
		send_sealed(ubx_nrd_pkg::KIND_NAV_POSLLH, fr, 1'b1);
		fr = build_frame(ubx_nrd_pkg::KIND_NAV_POSLLH);
		set_word(fr, 22, -32'sd1001);
		send_sealed(ubx_nrd_pkg::KIND_NAV_POSLLH, fr, 1'b1);

		// Fix flag clear and too few satellites: position is zeroed.
		fr = build_frame(ubx_nrd_pkg::KIND_NAV_SOL);
		fr[17] = 8'h00;
		fr[53] = 8'd3;
		send_sealed(ubx_nrd_pkg::KIND_NAV_SOL, fr, 1'b0);
		fr = build_frame(ubx_nrd_pkg::KIND_NAV_POSLLH);
		send_sealed(ubx_nrd_pkg::KIND_NAV_POSLLH, fr, 1'b1);

		// Latest valid time, then each field just out of range.
		for (int t = 0; t < 4; t++) begin
			fr = build_frame(ubx_nrd_pkg::KIND_NAV_TIMEUTC);
			fr[22] = (t == 1) ? 8'd24 : (t == 0) ? 8'd23 : 8'd0;
			fr[23] = (t == 2) ? 8'd60 : (t == 0) ? 8'd59 : 8'd0;
			fr[24] = (t == 3) ? 8'd60 : (t == 0) ? 8'd59 : 8'd0;
			send_sealed(ubx_nrd_pkg::KIND_NAV_TIMEUTC, fr, t[0]);
		end

		fr = build_frame(ubx_nrd_pkg::KIND_CFG_NAV5);
		fr[8] = 8'hFF;
		send_sealed(ubx_nrd_pkg::KIND_CFG_NAV5, fr, 1'b1);
		drain_reports();
	endtask

	// Checksum outranks id, id outranks sync; any NAV-SOL error clears the fix.
	task automatic test_status_priority();
		frame_q_t fr;

		fr = build_frame(ubx_nrd_pkg::KIND_NAV_SOL);
		fr[17] = 8'h01;
		fr[53] = 8'd9;
		send_sealed(ubx_nrd_pkg::KIND_NAV_SOL, fr, 1'b0);

		fr = build_frame(ubx_nrd_pkg::KIND_NAV_SOL);
		seal_frame(fr, ubx_nrd_pkg::KIND_NAV_SOL);
		fr[1] = 8'h00;
		send_frame(ubx_nrd_pkg::KIND_NAV_SOL, fr, ubx_nrd_pkg::KIND_NAV_SOL,
			FRAME_LEN, 1'b0);

		fr = build_frame(ubx_nrd_pkg::KIND_NAV_POSLLH);
		fr[0] = 8'h00;
		fr[3] = ubx_nrd_pkg::ID_TIMEUTC;
		seal_frame(fr, ubx_nrd_pkg::KIND_NAV_POSLLH);
		send_frame(ubx_nrd_pkg::KIND_NAV_POSLLH, fr, ubx_nrd_pkg::KIND_NAV_POSLLH,
			FRAME_LEN, 1'b1);

		fr = build_frame(ubx_nrd_pkg::KIND_NAV_TIMEUTC);
		seal_frame(fr, ubx_nrd_pkg::KIND_NAV_TIMEUTC);
		fr[0] = 8'h00;
		fr[2] = ubx_nrd_pkg::CLASS_CFG;
		fr[PAYLOAD_LEN[ubx_nrd_pkg::KIND_NAV_TIMEUTC] + 3] ^= 8'h01;
		send_frame(ubx_nrd_pkg::KIND_NAV_TIMEUTC, fr, ubx_nrd_pkg::KIND_NAV_TIMEUTC,
			FRAME_LEN, 1'b1);

		// The model byte is kept even from a reply with a bad checksum.
		fr = build_frame(ubx_nrd_pkg::KIND_CFG_NAV5);
		fr[8] = 8'h00;
		seal_frame(fr, ubx_nrd_pkg::KIND_CFG_NAV5);
		fr[PAYLOAD_LEN[ubx_nrd_pkg::KIND_CFG_NAV5] + 2] ^= 8'h80;
		send_frame(ubx_nrd_pkg::KIND_CFG_NAV5, fr, ubx_nrd_pkg::KIND_CFG_NAV5,
			FRAME_LEN, 1'b0);
		drain_reports();
	endtask

	// The kind changes part way through a frame.
	task automatic test_kind_switch();
		frame_q_t fr;
		fr = build_frame(ubx_nrd_pkg::KIND_NAV_POSLLH);
		seal_frame(fr, ubx_nrd_pkg::KIND_NAV_POSLLH);
		send_frame(ubx_nrd_pkg::KIND_NAV_POSLLH, fr, ubx_nrd_pkg::KIND_NAV_TIMEUTC,
			20, 1'b1);
		fr = build_frame(ubx_nrd_pkg::KIND_CFG_NAV5);
		seal_frame(fr, ubx_nrd_pkg::KIND_CFG_NAV5);
		send_frame(ubx_nrd_pkg::KIND_CFG_NAV5, fr, ubx_nrd_pkg::KIND_NAV_SOL, 3, 1'b0);
		drain_reports();
	endtask

	// The receiver holds off while timeouts keep arriving, so the block
	// fills up and stalls its input.
	task automatic test_backpressure();
		gaps_on = 1'b0;
		hold_len = HOLD_CYCLES;
		for (int i = 0; i < 40; i++)
			send_item(ubx_nrd_pkg::kind_t'($urandom_range(0, 3)),
				ubx_nrd_pkg::byte_t'($urandom_range(0, 255)), 1'b1);
		drain_reports();
		gaps_on = 1'b1;
	endtask

	// Mostly well-formed replies with random content, then corrupted,
	// truncated, kind-switched frames and plain noise.
	task automatic test_random_frames();
		frame_q_t fr;
		ubx_nrd_pkg::kind_t k, k2;
		int mode, frame_no, n;
		frame_no = 0;
		while (items_sent < ITEMS_TARGET || frame_no < MIN_FRAMES) begin
			// A stretch of frames with no idling on either side.
			gaps_on = !(frame_no >= 8 && frame_no < 16);
			// Realign after noise that left a frame open.
			if (nav_pos != 0)
				send_item(ubx_nrd_pkg::kind_t'($urandom_range(0, 3)),
					ubx_nrd_pkg::byte_t'($urandom_range(0, 255)), 1'b1);
			k = ubx_nrd_pkg::kind_t'($urandom_range(0, 3));
			k2 = ubx_nrd_pkg::kind_t'($urandom_range(0, 3));
			fr = build_frame(k);
			seal_frame(fr, k);
			mode = $urandom_range(0, 99);
			if (mode < 65) begin
				send_frame(k, fr, k, FRAME_LEN, 1'($urandom_range(0, 1)));
			end else if (mode < 75) begin
				n = $urandom_range(0, fr.size() - 1);
				fr[n] ^= ubx_nrd_pkg::byte_t'($urandom_range(1, 255));
				send_frame(k, fr, k, FRAME_LEN, 1'($urandom_range(0, 1)));
			end else if (mode < 83) begin
				n = $urandom_range(0, fr.size() - 1);
				while (fr.size() > n) fr.delete(fr.size() - 1);
				send_frame(k, fr, k, FRAME_LEN, 1'b1);
			end else if (mode < 91) begin
				send_frame(k, fr, k2, $urandom_range(0, fr.size()),
					1'($urandom_range(0, 1)));
			end else begin
				n = $urandom_range(0, 70);
				for (int i = 0; i < n; i++)
					send_item(ubx_nrd_pkg::kind_t'($urandom_range(0, 3)),
						ubx_nrd_pkg::byte_t'($urandom_range(0, 255)), 1'b0);
			end
			frame_no++;
		end
		gaps_on = 1'b1;
		drain_reports();
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin : main_seq
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_timeouts();
		test_wellformed_frames();
		test_status_priority();
		test_kind_switch();
		test_backpressure();
		test_random_frames();
		drain_reports();
		$display("Decoded %0d frames of all four reply kinds from %0d byte transfers.",
			frames_closed, items_sent);
		$display("%0d frames passed every check, %0d ended on a timeout, %0d results compared.",
			clean_frames, cuts_sent, reports_checked);
		if (mismatches == 0 && pending_reports.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

`default_nettype wire

[ubx_nav_response_decoder.f]
hdl/ubx_nrd_pkg.sv
hdl/ubx_nav_response_decoder.sv
test/ubx_nav_response_decoder_test.sv
